>>> design/icm_pkg.sv
// shared types and constants of the incremental conductance tracker
`default_nettype none

package icm_pkg;

  localparam int QFracBitsDefault = 24;

  // register reset values
  localparam logic        TrackEnableReset = 1'b1;
  localparam logic [24:0] StepSizeReset    = 25'd167772;
  localparam logic [31:0] MinVoltageReset  = 32'd0;
  localparam logic [31:0] MaxVoltageReset  = 32'd16777216;
  localparam logic [23:0] IntervalReset    = 24'd100000;
  localparam logic [23:0] SkipCountReset   = 24'd100000;

  localparam logic [31:0] S32Max = 32'h7fff_ffff;
  localparam logic [31:0] S32Min = 32'h8000_0000;

  typedef enum logic [2:0] {
    CFG_TRACK_ENABLE      = 3'd0,
    CFG_STEP_SIZE         = 3'd1,
    CFG_MIN_VOLTAGE       = 3'd2,
    CFG_MAX_VOLTAGE       = 3'd3,
    CFG_DECISION_INTERVAL = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               track_enable;
    logic [24:0]        step_size;
    logic signed [31:0] min_voltage;
    logic signed [31:0] max_voltage;
    logic [23:0]        decision_interval;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] voltage_sample;
    logic signed [31:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] voltage_reference;
    logic signed [31:0] filtered_voltage;
    logic signed [31:0] filtered_current;
    logic               decision_made;
  } out_item_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_A_CS  = 3'd1,
    MUL_B_CF  = 3'd2,
    MUL_A_VS  = 3'd3,
    MUL_B_VF  = 3'd4,
    MUL_DI_VF = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     acc_ld;
    logic     cf_ld;
    logic     vf_ld;
    logic     first_ld;
    logic     cnt_dec;
    logic     diff_ld;
    logic     div_start;
    logic     dir_ld;
    logic     cand_ld;
    logic     clamp_ld;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic first;
    logic cnt_zero;
    logic dv_zero;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

>>> design/icm_div.sv
// serial restoring divider, numerator scaled by 2^q, saturating signed quotient
`default_nettype none

module icm_div #(
  parameter int QF = icm_pkg::QFracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  import icm_pkg::*;

  localparam int NW = 32 + QF;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   rem_q, rem_d;
  logic [NW-1:0] sh_q, sh_d;
  logic [31:0]   dmag_q, dmag_d;
  logic          neg_q, neg_d;

  logic [32:0] trial;
  logic        ge;
  logic [31:0] nmag, dmag;
  logic        too_big_pos, too_big_neg;

  assign nmag  = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign dmag  = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign trial = {rem_q, sh_q[NW-1]};
  assign ge    = trial >= {1'b0, dmag_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      sh_d   = {nmag, {QF{1'b0}}};
      dmag_d = dmag;
      neg_d  = num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_d = ge ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
      sh_d  = {sh_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  // saturate the magnitude to the signed 32-bit range
  assign too_big_pos = |sh_q[NW-1:31];
  assign too_big_neg = (|sh_q[NW-1:32]) | (sh_q[31] & (|sh_q[30:0]));

  always_comb begin
    if (!neg_q) begin
      quot_o = too_big_pos ? S32Max : sh_q[31:0];
    end else begin
      quot_o = too_big_neg ? S32Min : 32'(-sh_q[31:0]);
    end
  end

  assign done_o = !busy_q;

endmodule

`default_nettype wire

>>> design/icm_dp.sv
// datapath: filters, shared multiplier, tracking state and result register
`default_nettype none

module icm_dp #(
  parameter int QF = icm_pkg::QFracBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire icm_pkg::cfg_t       cfg_i,
  input  wire icm_pkg::cmd_t       cmd_i,
  output icm_pkg::status_t         st_o,
  input  wire icm_pkg::in_item_t   in_data_i,
  output icm_pkg::out_item_t       out_data_o
);
  import icm_pkg::*;

  localparam longint AlphaL     = (longint'(666) << QF) / 10000;
  localparam longint BetaL      = (longint'(9334) << QF) / 10000;
  localparam longint FirstStepL = (longint'(1) << QF) / 100;
  localparam logic signed [31:0] Alpha     = 32'(AlphaL);
  localparam logic signed [31:0] Beta      = 32'(BetaL);
  localparam logic signed [32:0] FirstStep = 33'(FirstStepL);

  logic signed [31:0] vs_q, cs_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] acc_q;
  logic signed [31:0] vf_q, cf_q, vprev_q, cprev_q, ref_q;
  logic signed [31:0] dv_q, di_q;
  logic               first_q;
  logic [23:0]        cnt_q;
  logic               up_q, dn_q;
  logic signed [33:0] cand_q;
  logic               decided_q;
  out_item_t          out_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] prod_tr;
  logic signed [32:0] first_sum;
  logic signed [31:0] first_ref;
  logic               div_done;
  logic signed [31:0] quot;
  logic signed [32:0] tsum;
  logic               up_d, dn_d;
  logic signed [33:0] vf_ext, step_ext, cand_d;
  logic signed [33:0] min_ext, max_ext, lo_clamped, clamped;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_A_CS: begin mul_a = Alpha; mul_b = cs_q; end
      MUL_B_CF: begin mul_a = Beta;  mul_b = cf_q; end
      MUL_A_VS: begin mul_a = Alpha; mul_b = vs_q; end
      MUL_B_VF: begin mul_a = Beta;  mul_b = vf_q; end
      MUL_DI_VF: begin mul_a = di_q; mul_b = vf_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // product shifted right by q and wrapped to 32 bits
  assign prod_tr = prod_q[QF +: 32];

  assign first_sum = {vf_q[31], vf_q} + FirstStep;
  always_comb begin
    case (first_sum[32:31])
      2'b01:   first_ref = S32Max;
      2'b10:   first_ref = S32Min;
      default: first_ref = first_sum[31:0];
    endcase
  end

  icm_div #(.QF(QF)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_tr),
    .den_i   (dv_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // direction from the incremental conductance test
  assign tsum = {cf_q[31], cf_q} + {quot[31], quot};
  always_comb begin
    if (dv_q == '0) begin
      up_d = !di_q[31] && (di_q != '0);
      dn_d = di_q[31];
    end else begin
      up_d = !tsum[32] && (tsum != '0);
      dn_d = tsum[32];
    end
  end

  assign vf_ext   = {{2{vf_q[31]}}, vf_q};
  assign step_ext = {9'b0, cfg_i.step_size};
  always_comb begin
    if (up_q) begin
      cand_d = vf_ext + step_ext;
    end else if (dn_q) begin
      cand_d = vf_ext - step_ext;
    end else begin
      cand_d = {{2{ref_q[31]}}, ref_q};
    end
  end

  // min first, then max, so max wins
  assign min_ext    = {{2{cfg_i.min_voltage[31]}}, cfg_i.min_voltage};
  assign max_ext    = {{2{cfg_i.max_voltage[31]}}, cfg_i.max_voltage};
  assign lo_clamped = (cand_q < min_ext) ? min_ext : cand_q;
  assign clamped    = (lo_clamped > max_ext) ? max_ext : lo_clamped;

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q      <= '0;
      cf_q      <= '0;
      vprev_q   <= '0;
      cprev_q   <= '0;
      ref_q     <= '0;
      first_q   <= 1'b1;
      cnt_q     <= SkipCountReset;
      decided_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        decided_q <= 1'b0;
      end
      if (cmd_i.cf_ld) begin
        cf_q <= acc_q + prod_tr;
      end
      if (cmd_i.vf_ld) begin
        vf_q <= acc_q + prod_tr;
      end
      if (cmd_i.first_ld) begin
        ref_q     <= first_ref;
        first_q   <= 1'b0;
        vprev_q   <= vf_q;
        cprev_q   <= cf_q;
        cnt_q     <= cfg_i.decision_interval;
        decided_q <= 1'b1;
      end
      if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.diff_ld) begin
        vprev_q <= vf_q;
        cprev_q <= cf_q;
        cnt_q   <= cfg_i.decision_interval;
      end
      if (cmd_i.clamp_ld) begin
        ref_q     <= clamped[31:0];
        decided_q <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vs_q <= in_data_i.voltage_sample;
      cs_q <= in_data_i.current_sample;
    end
    if (cmd_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_ld) begin
      acc_q <= prod_tr;
    end
    if (cmd_i.diff_ld) begin
      dv_q <= vf_q - vprev_q;
      di_q <= cf_q - cprev_q;
    end
    if (cmd_i.dir_ld) begin
      up_q <= up_d;
      dn_q <= dn_d;
    end
    if (cmd_i.cand_ld) begin
      cand_q <= cand_d;
    end
    if (cmd_i.out_ld) begin
      out_q.voltage_reference <= ref_q;
      out_q.filtered_voltage  <= vf_q;
      out_q.filtered_current  <= cf_q;
      out_q.decision_made     <= decided_q;
    end
  end

  assign st_o.enable   = cfg_i.track_enable;
  assign st_o.first    = first_q;
  assign st_o.cnt_zero = (cnt_q == '0);
  assign st_o.dv_zero  = (dv_q == '0);
  assign st_o.div_done = div_done;

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> design/icm_ctrl.sv
// sequencing state machine and result valid flag
`default_nettype none

module icm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire icm_pkg::status_t st_i,
  output icm_pkg::cmd_t         cmd_o
);
  import icm_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_FC1     = 14'b00000000000010,
    S_FC2     = 14'b00000000000100,
    S_FC3     = 14'b00000000001000,
    S_FV2     = 14'b00000000010000,
    S_FV3     = 14'b00000000100000,
    S_BRANCH  = 14'b00000001000000,
    S_DMUL    = 14'b00000010000000,
    S_DIVGO   = 14'b00000100000000,
    S_DIVWAIT = 14'b00001000000000,
    S_TSUM    = 14'b00010000000000,
    S_STEP    = 14'b00100000000000,
    S_CLAMP   = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_FC1;
        end
      end
      S_FC1: begin
        cmd_o.mul_sel = MUL_A_CS;
        state_d       = S_FC2;
      end
      S_FC2: begin
        cmd_o.acc_ld  = 1'b1;
        cmd_o.mul_sel = MUL_B_CF;
        state_d       = S_FC3;
      end
      S_FC3: begin
        cmd_o.cf_ld   = 1'b1;
        cmd_o.mul_sel = MUL_A_VS;
        state_d       = S_FV2;
      end
      S_FV2: begin
        cmd_o.acc_ld  = 1'b1;
        cmd_o.mul_sel = MUL_B_VF;
        state_d       = S_FV3;
      end
      S_FV3: begin
        cmd_o.vf_ld = 1'b1;
        state_d     = S_BRANCH;
      end
      S_BRANCH: begin
        if (!st_i.enable) begin
          state_d = S_DONE;
        end else if (st_i.first) begin
          cmd_o.first_ld = 1'b1;
          state_d        = S_DONE;
        end else if (!st_i.cnt_zero) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.diff_ld = 1'b1;
          state_d       = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd_o.mul_sel = MUL_DI_VF;
        state_d       = st_i.dv_zero ? S_TSUM : S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (st_i.div_done) begin
          state_d = S_TSUM;
        end
      end
      S_TSUM: begin
        cmd_o.dir_ld = 1'b1;
        state_d      = S_STEP;
      end
      S_STEP: begin
        cmd_o.cand_ld = 1'b1;
        state_d       = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp_ld = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/incremental_conductance_mppt.sv
// top level of the incremental conductance maximum power point tracker
`default_nettype none

// One transfer in carries a raw voltage and current sample (signed Q8.24 at the
// default fraction width); one transfer out returns the voltage reference, both
// filtered values and a flag telling whether this sample ran the first step or
// a tracking decision. Both samples go through first-order low-pass filters on
// a single shared 32x32 multiplier, four multiplies back to back. A sample that
// only filters, counts down or takes the first step has its result loaded
// after the filter and branch steps, and the next sample can be taken in the
// cycle after that load. A tracking decision with an unchanged voltage adds
// one multiply and the direction, step and clamp steps. Any other decision
// also runs a one-bit-per-cycle divider of 32 + Q_FRACTION_BITS steps, with
// a start step before it and a wait on its done flag. Only one sample is in
// work at a time; a new sample is taken while the previous result still waits
// in the output register, and a finished sample holds in its last step until
// the receiver takes that waiting result. Registers are written through
// cfg_we_i / cfg_index_i / cfg_wdata_i and must only change while the block
// is idle. There is no clearing pass after reset.
module incremental_conductance_mppt #(
  parameter int Q_FRACTION_BITS = icm_pkg::QFracBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire icm_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output icm_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  import icm_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t st;

  // configuration registers, fields truncated to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_enable      <= TrackEnableReset;
      cfg_q.step_size         <= StepSizeReset;
      cfg_q.min_voltage       <= MinVoltageReset;
      cfg_q.max_voltage       <= MaxVoltageReset;
      cfg_q.decision_interval <= IntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRACK_ENABLE:      cfg_q.track_enable      <= cfg_wdata_i[0];
        CFG_STEP_SIZE:         cfg_q.step_size         <= cfg_wdata_i[24:0];
        CFG_MIN_VOLTAGE:       cfg_q.min_voltage       <= cfg_wdata_i;
        CFG_MAX_VOLTAGE:       cfg_q.max_voltage       <= cfg_wdata_i;
        CFG_DECISION_INTERVAL: cfg_q.decision_interval <= cfg_wdata_i[23:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // sequencer: walks filter, branch and decision steps
  icm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // arithmetic, tracker state and output register
  icm_dp #(.QF(Q_FRACTION_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> design/icm_checker.sv
// port-level checks of the tracker and their binding to the top level
`default_nettype none

module icm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire icm_pkg::out_item_t out_data_o
);

  logic [1:0] inflight_q, inflight_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // one sample in work at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while a sample is in work");

  // no result without a sample behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != 2'd0))
    else $error("result shown with no sample outstanding");

  // at most one waiting result plus one sample in work
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("too many samples outstanding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

endmodule

bind incremental_conductance_mppt icm_checker u_icm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> tb/sv/tb_incremental_conductance_mppt.sv
// self-checking testbench of the incremental conductance tracker with a built-in predictor
`default_nettype none

module tb_incremental_conductance_mppt;
  timeunit 1ns;
  timeprecision 1ps;

  import icm_pkg::*;

  // fixed-point constants of the tracker at the default fraction width
  localparam int     QFrac      = QFracBitsDefault;
  localparam int     AlphaQ     = int'((64'sd666 <<< QFrac) / 64'sd10000);
  localparam int     BetaQ      = int'((64'sd9334 <<< QFrac) / 64'sd10000);
  localparam longint FirstStepQ = (64'sd1 <<< QFrac) / 64'sd100;
  localparam longint S32Top     = 64'sd2147483647;
  localparam longint S32Bottom  = -64'sd2147483648;

  // run control
  localparam int ResetCycles = 10;
  localparam int DrainCycles = 8;    // block is idle once the last result is out
  localparam int EndCycles   = 100;
  localparam int StallLimit  = 5000; // cycles without any transfer
  localparam int ReportCap   = 100;  // keeps the log short on a badly broken block

  // predicts every result of the tracker and checks the block's results in order
  class mppt_checker;
    // register copies
    logic        track_on   = TrackEnableReset;
    logic [24:0] step_q     = StepSizeReset;
    int          clamp_lo   = MinVoltageReset;
    int          clamp_hi   = MaxVoltageReset;
    logic [23:0] interval_q = IntervalReset;
    // tracker state
    int          volt_avg = 0;
    int          curr_avg = 0;
    int          volt_last = 0;
    int          curr_last = 0;
    int          vref = 0;
    logic        awaiting_first = 1'b1;
    logic [23:0] hold_count = SkipCountReset;

    out_item_t   expected_q[$];
    int unsigned mismatches = 0;

    // product shifted down with floor, then wrapped to 32 bits
    static function int q_mul(int a, int b);
      longint prod;
      prod = longint'(a) * longint'(b);
      prod = prod >>> QFrac;
      return int'(prod);
    endfunction

    static function int sat32(longint x);
      if (x > S32Top) return int'(S32Top);
      if (x < S32Bottom) return int'(S32Bottom);
      return int'(x);
    endfunction

    // quotient truncated toward zero, saturated
    static function int q_div(int n, int d);
      longint quo;
      quo = (longint'(n) <<< QFrac) / longint'(d);
      return sat32(quo);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_TRACK_ENABLE:      track_on = data[0];
        CFG_STEP_SIZE:         step_q = data[24:0];
        CFG_MIN_VOLTAGE:       clamp_lo = data;
        CFG_MAX_VOLTAGE:       clamp_hi = data;
        CFG_DECISION_INTERVAL: interval_q = data[23:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(in_item_t s);
      int        dv;
      int        di;
      longint    sum;
      longint    nxt;
      out_item_t res;
      curr_avg = q_mul(AlphaQ, s.current_sample) + q_mul(BetaQ, curr_avg);
      volt_avg = q_mul(AlphaQ, s.voltage_sample) + q_mul(BetaQ, volt_avg);
      res.decision_made = 1'b0;
      if (track_on) begin
        if (awaiting_first) begin
          // first step saturates and skips the clamps
          vref = sat32(longint'(volt_avg) + FirstStepQ);
          awaiting_first = 1'b0;
          volt_last = volt_avg;
          curr_last = curr_avg;
          hold_count = interval_q;
          res.decision_made = 1'b1;
        end else if (hold_count == 0) begin
          dv = volt_avg - volt_last;
          di = curr_avg - curr_last;
          if (dv == 0) begin
            sum = di;
          end else begin
            sum = longint'(curr_avg) + longint'(q_div(q_mul(di, volt_avg), dv));
          end
          nxt = vref;
          if (sum > 0) nxt = longint'(volt_avg) + longint'(step_q);
          else if (sum < 0) nxt = longint'(volt_avg) - longint'(step_q);
          volt_last = volt_avg;
          curr_last = curr_avg;
          if (nxt < clamp_lo) nxt = clamp_lo;
          if (nxt > clamp_hi) nxt = clamp_hi;
          vref = int'(nxt);
          hold_count = interval_q;
          res.decision_made = 1'b1;
        end else begin
          hold_count = hold_count - 1'b1;
        end
      end
      res.voltage_reference = vref;
      res.filtered_voltage  = volt_avg;
      res.filtered_current  = curr_avg;
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
      mismatches++;
      if (mismatches <= ReportCap)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with no sample waiting, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.voltage_reference !== want.voltage_reference)
        report("voltage_reference", want.voltage_reference, got.voltage_reference);
      if (got.filtered_voltage !== want.filtered_voltage)
        report("filtered_voltage", want.filtered_voltage, got.filtered_voltage);
      if (got.filtered_current !== want.filtered_current)
        report("filtered_current", want.filtered_current, got.filtered_current);
      if (got.decision_made !== want.decision_made)
        report("decision_made", 32'(want.decision_made), 32'(got.decision_made));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  mppt_checker board = new();

  // idle percentages of the sample sender and the result receiver
  int send_idle_pct = 22;
  int recv_idle_pct = 45;
  int quiet_cycles = 0;

  // operating point of the synthetic panel and the last sample sent
  int       panel_v = 1 << 24;
  in_item_t last_sample = '0;

  incremental_conductance_mppt uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // both channels are sampled on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_sample(in_data_i);
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function int corner_value();
    case ($urandom_range(0, 4))
      0:       return int'(S32Max);
      1:       return int'(S32Min);
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  // mostly a slowly drifting operating point on a rough panel curve,
  // the rest full-range noise, corner values and repeats
  function in_item_t next_sample();
    in_item_t s;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      s.voltage_sample = $urandom;
      s.current_sample = $urandom;
    end else if (pick < 30) begin
      s = last_sample;
    end else if (pick < 36) begin
      s.voltage_sample = corner_value();
      s.current_sample = corner_value();
    end else begin
      panel_v += int'($urandom_range(0, 1 << 20)) - (1 << 19);
      if (panel_v < 0) panel_v = 0;
      if (panel_v > (1 << 25)) panel_v = 1 << 25;
      s.voltage_sample = panel_v;
      s.current_sample = ((1 << 25) - panel_v) / 2 + int'($urandom_range(0, 1 << 16))
                         - (1 << 15);
    end
    last_sample = s;
    return s;
  endfunction

  // holds valid and payload until the transfer; valid only drops when idling
  task automatic send_sample(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_pair(input int volt, input int curr);
    in_item_t item;
    item.voltage_sample = volt;
    item.current_sample = curr;
    send_sample(item);
  endtask

  // sender pauses until every expected result is back
  task automatic wait_results_in(input int settle);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // all registers are rewritten with the block idle
  task automatic apply_settings(input logic en, input logic [24:0] step, input int lo,
                                input int hi, input logic [23:0] interval);
    wait_results_in(DrainCycles);
    write_reg(CFG_TRACK_ENABLE, {31'b0, en});
    write_reg(CFG_STEP_SIZE, {7'b0, step});
    write_reg(CFG_MIN_VOLTAGE, lo);
    write_reg(CFG_MAX_VOLTAGE, hi);
    write_reg(CFG_DECISION_INTERVAL, {8'b0, interval});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_sample(next_sample());
      // mid-phase drain so the sender also waits on an empty pipeline
      if (k == count / 2 || $urandom_range(0, 199) == 0) wait_results_in(0);
    end
  endtask

  task automatic random_phase(input int count);
    int lo;
    lo = int'($urandom_range(0, 1 << 24)) - (1 << 23);
    apply_settings(1'b1, 25'($urandom_range(0, 1 << 24)), lo,
                   lo + int'($urandom_range(0, 1 << 25)), 24'($urandom_range(0, 5)));
    send_random(count);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_TRACK_ENABLE;
    cfg_wdata_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // tracking off: filters only, first step stays pending, counter holds
    apply_settings(1'b0, StepSizeReset, MinVoltageReset, MaxVoltageReset, 24'd0);
    send_pair(int'(S32Max), int'(S32Min));
    send_pair(int'(S32Min), int'(S32Max));
    send_pair(0, 0);
    send_pair(1, -1);
    send_pair(-1, 1);
    // drive the voltage filter close to full scale
    repeat (200) send_pair(int'(S32Max), $urandom);

    // first step: filtered voltage plus the offset saturates, no clamping
    apply_settings(1'b1, StepSizeReset, MinVoltageReset, MaxVoltageReset, 24'd0);
    send_pair(int'(S32Max), 0);
    // decisions on extremes: product wrap and divider saturation
    send_pair(int'(S32Max), int'(S32Max));
    send_pair(int'(S32Min), int'(S32Min));
    send_pair(int'(S32Max), int'(S32Min));
    send_pair(int'(S32Min), int'(S32Max));
    send_pair(1, -1);
    send_pair(-1, 1);

    // let both filters settle on zero input; the counter runs out on the last sample
    apply_settings(1'b1, StepSizeReset, 0, MaxVoltageReset, 24'd499);
    repeat (500) send_pair(0, 0);

    // flat voltage: no current change means no move, then current up and down
    apply_settings(1'b1, 25'h100_0000, -(1 << 24), 1 << 24, 24'd0);
    send_pair(0, 0);
    send_pair(0, 0);
    send_pair(0, int'(S32Max));
    send_pair(0, int'(S32Min));
    send_pair(0, 1);

    // random phases with the sender idling less than the receiver
    send_idle_pct = 22;
    recv_idle_pct = 45;
    apply_settings(1'b1, StepSizeReset, 0, 1 << 24, 24'd0);
    send_random(120);
    apply_settings(1'b1, 25'd0, int'(S32Min), int'(S32Max), 24'd1);
    send_random(120);
    apply_settings(1'b1, 25'h100_0000, -(1 << 24), 1 << 25, 24'd2);
    send_random(120);
    // lower clamp above the upper one: upper clamp wins
    apply_settings(1'b1, StepSizeReset, 1 << 24, 0, 24'd0);
    send_random(120);

    // the other way round
    send_idle_pct = 45;
    recv_idle_pct = 22;
    begin
      int pin;
      pin = $urandom;
      apply_settings(1'b1, 25'($urandom_range(0, 1 << 24)), pin, pin, 24'd3);
    end
    send_random(120);
    apply_settings(1'b0, 25'($urandom_range(0, 1 << 24)), $urandom, $urandom, 24'd0);
    send_random(120);
    repeat (2) random_phase(120);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) random_phase(120);
    // longest interval last: after its first decision no other one comes
    apply_settings(1'b1, StepSizeReset, 0, 1 << 25, 24'hff_ffff);
    send_random(120);

    wait_results_in(EndCycles);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
